>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/utj_pkg.sv
package utj_pkg;

   // kinds of expansion job handed from the decoder to the emitter
   localparam logic [2:0] KIND_CHAR = 3'd0;   // one character as is
   localparam logic [2:0] KIND_ESC  = 3'd1;   // backslash then one character
   localparam logic [2:0] KIND_U16  = 3'd2;   // \uXXXX
   localparam logic [2:0] KIND_PAIR = 3'd3;   // \uXXXX\uXXXX surrogate pair
   localparam logic [2:0] KIND_ERR  = 3'd4;   // single error beat

   localparam logic [6:0] CH_QUOTE  = 7'h22;
   localparam logic [6:0] CH_BSLASH = 7'h5C;
   localparam logic [6:0] CH_U      = 7'h75;
   localparam logic [6:0] CH_ZERO   = 7'h30;
   localparam logic [6:0] CH_UPPER_A = 7'h41;
   localparam logic [6:0] CH_LOWER_A = 7'h61;

   localparam logic [6:0]  CTRL_LIMIT   = 7'h20;
   localparam logic [20:0] BMP_LIMIT    = 21'h10000;
   localparam logic [20:0] MAX_CODE     = 21'h10FFFF;
   localparam logic [15:0] SURR_HI_BASE = 16'hD7C0;
   localparam logic [5:0]  SURR_LO_TAG  = 6'h37;   // top six bits of 0xDC00

   typedef struct packed {
      logic [2:0]  kind;
      logic [6:0]  ch;
      logic [15:0] hi;
      logic [15:0] lo;
   } job_type;

endpackage

>>> rtl/utj_front.sv
`include "assert_macros.svh"

module utj_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             req_end_of_text,
   input  logic             space,
   output logic             job_valid,
   output utj_pkg::job_type job
);

   localparam logic [6:0] C_BACKSPACE = 7'h08;
   localparam logic [6:0] C_TAB       = 7'h09;
   localparam logic [6:0] C_NEWLINE   = 7'h0A;
   localparam logic [6:0] C_FORMFEED  = 7'h0C;
   localparam logic [6:0] C_RETURN    = 7'h0D;
   localparam logic [6:0] C_LETTER_B  = 7'h62;
   localparam logic [6:0] C_LETTER_F  = 7'h66;
   localparam logic [6:0] C_LETTER_N  = 7'h6E;
   localparam logic [6:0] C_LETTER_R  = 7'h72;
   localparam logic [6:0] C_LETTER_T  = 7'h74;

   logic [20:0] code_acc_ff, code_acc_in;
   logic [2:0]  seq_len_ff, seq_len_in;
   logic [2:0]  seq_got_ff, seq_got_in;
   logic        accept;
   logic [2:0]  lead_len;
   logic [20:0] code;

   // keep only the bits the gathered byte count carries
   function automatic logic [20:0] trim_code(input logic [20:0] acc, input logic [2:0] got);
      logic [20:0] res;
      case (got)
         3'd1:    res = {15'b0, acc[5:0]};
         3'd2:    res = {10'b0, acc[10:0]};
         3'd3:    res = {5'b0, acc[15:0]};
         default: res = acc;
      endcase
      return res;
   endfunction

   assign req_ready = space;
   assign accept    = req_valid && space;

   always_comb begin
      if (!req_in_byte[6])      lead_len = 3'd1;
      else if (!req_in_byte[5]) lead_len = 3'd2;
      else if (!req_in_byte[4]) lead_len = 3'd3;
      else                      lead_len = 3'd4;
   end

   always_comb begin
      code_acc_in = code_acc_ff;
      seq_len_in  = seq_len_ff;
      seq_got_in  = seq_got_ff;
      job_valid   = 1'b0;
      job         = '0;
      code        = '0;
      if (accept) begin
         if (seq_len_ff == 3'd0) begin
            if (!req_in_byte[7]) begin
               job_valid = 1'b1;
               job.ch    = req_in_byte[6:0];
               case (req_in_byte[6:0])
                  utj_pkg::CH_QUOTE, utj_pkg::CH_BSLASH: begin
                     job.kind = utj_pkg::KIND_ESC;
                  end
                  C_BACKSPACE: begin
                     job.kind = utj_pkg::KIND_ESC;
                     job.ch   = C_LETTER_B;
                  end
                  C_FORMFEED: begin
                     job.kind = utj_pkg::KIND_ESC;
                     job.ch   = C_LETTER_F;
                  end
                  C_NEWLINE: begin
                     job.kind = utj_pkg::KIND_ESC;
                     job.ch   = C_LETTER_N;
                  end
                  C_RETURN: begin
                     job.kind = utj_pkg::KIND_ESC;
                     job.ch   = C_LETTER_R;
                  end
                  C_TAB: begin
                     job.kind = utj_pkg::KIND_ESC;
                     job.ch   = C_LETTER_T;
                  end
                  default: begin
                     if (req_in_byte[6:0] < utj_pkg::CTRL_LIMIT) begin
                        job.kind = utj_pkg::KIND_U16;
                        job.hi   = {9'b0, req_in_byte[6:0]};
                     end else begin
                        job.kind = utj_pkg::KIND_CHAR;
                     end
                  end
               endcase
            end else if (req_in_byte[6:3] == 4'hF) begin
               // lead byte 0xf8 and above
               job_valid = 1'b1;
               job.kind  = utj_pkg::KIND_ERR;
            end else begin
               code_acc_in = {15'b0, req_in_byte[5:0]};
               seq_len_in  = lead_len;
               seq_got_in  = 3'd1;
            end
         end else begin
            // continuation bytes are taken unchecked
            code_acc_in = {code_acc_ff[14:0], req_in_byte[5:0]};
            seq_got_in  = seq_got_ff + 3'd1;
         end

         if (seq_len_in != 3'd0 && (seq_got_in >= seq_len_in || req_end_of_text)) begin
            code      = trim_code(code_acc_in, seq_got_in);
            job_valid = 1'b1;
            if (code < utj_pkg::BMP_LIMIT) begin
               job.kind = utj_pkg::KIND_U16;
               job.hi   = code[15:0];
            end else if (code <= utj_pkg::MAX_CODE) begin
               job.kind = utj_pkg::KIND_PAIR;
               job.hi   = 16'(code[20:10]) + utj_pkg::SURR_HI_BASE;
               job.lo   = {utj_pkg::SURR_LO_TAG, code[9:0]};
            end else begin
               job.kind = utj_pkg::KIND_ERR;
            end
            code_acc_in = '0;
            seq_len_in  = 3'd0;
            seq_got_in  = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_acc_ff <= '0;
         seq_len_ff  <= 3'd0;
         seq_got_ff  <= 3'd0;
      end else begin
         code_acc_ff <= code_acc_in;
         seq_len_ff  <= seq_len_in;
         seq_got_ff  <= seq_got_in;
      end
   end

   `ASSERT_CLK(a_idle_clean, clock, reset, (seq_len_ff == 3'd0) |-> (seq_got_ff == 3'd0 && code_acc_ff == 21'd0), "decoder idle with stale assembly")
   `ASSERT_CLK(a_got_bound, clock, reset, (seq_len_ff != 3'd0) |-> (seq_got_ff < seq_len_ff && seq_got_ff != 3'd0), "open sequence byte count out of range")

endmodule

>>> rtl/utj_queue.sv
`include "assert_macros.svh"

module utj_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  utj_pkg::job_type push_job,
   output logic             space,
   input  logic             pop,
   output logic             head_valid,
   output utj_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   utj_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign space      = count_ff != CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   `ASSERT_NEVER(a_push_full, clock, reset, push && !space, "beat pushed into full queue")
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && !head_valid, "pop from empty queue")

endmodule

>>> rtl/utj_back.sv
`include "assert_macros.svh"

module utj_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             hex_upper,
   input  logic             head_valid,
   input  utj_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [6:0]       rsp_out_char,
   output logic             rsp_last,
   output logic             rsp_error
);

   logic [3:0]  idx_ff, idx_in;
   logic [3:0]  total;
   logic        low_half;
   logic [2:0]  pos;
   logic [15:0] word;
   logic [3:0]  nib;
   logic [6:0]  hex_char;
   logic        fire;

   always_comb begin
      case (head_job.kind)
         utj_pkg::KIND_ESC:  total = 4'd2;
         utj_pkg::KIND_U16:  total = 4'd6;
         utj_pkg::KIND_PAIR: total = 4'd12;
         default:            total = 4'd1;
      endcase
   end

   // second half of a surrogate pair uses the low word
   assign low_half = idx_ff >= 4'd6;
   assign pos      = low_half ? 3'(idx_ff - 4'd6) : idx_ff[2:0];
   assign word     = low_half ? head_job.lo : head_job.hi;

   always_comb begin
      case (pos)
         3'd2:    nib = word[15:12];
         3'd3:    nib = word[11:8];
         3'd4:    nib = word[7:4];
         default: nib = word[3:0];
      endcase
      if (nib < 4'd10)
         hex_char = utj_pkg::CH_ZERO + 7'(nib);
      else
         hex_char = (hex_upper ? utj_pkg::CH_UPPER_A : utj_pkg::CH_LOWER_A) + 7'(nib) - 7'd10;
   end

   always_comb begin
      case (head_job.kind)
         utj_pkg::KIND_CHAR: rsp_out_char = head_job.ch;
         utj_pkg::KIND_ESC:  rsp_out_char = (idx_ff == 4'd0) ? utj_pkg::CH_BSLASH : head_job.ch;
         utj_pkg::KIND_U16, utj_pkg::KIND_PAIR: begin
            if (pos == 3'd0)      rsp_out_char = utj_pkg::CH_BSLASH;
            else if (pos == 3'd1) rsp_out_char = utj_pkg::CH_U;
            else                  rsp_out_char = hex_char;
         end
         default: rsp_out_char = 7'd0;
      endcase
   end

   assign rsp_valid = head_valid;
   assign rsp_last  = idx_ff == total - 4'd1;
   assign rsp_error = head_job.kind == utj_pkg::KIND_ERR;
   assign fire      = rsp_valid && rsp_ready;
   assign pop       = fire && rsp_last;

   always_comb begin
      idx_in = idx_ff;
      if (fire) idx_in = rsp_last ? 4'd0 : idx_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 4'd0;
      else       idx_ff <= idx_in;
   end

   `ASSERT_CLK(a_idx_bound, clock, reset, rsp_valid |-> (idx_ff < total), "character index beyond job length")
   `ASSERT_CLK(a_err_alone, clock, reset, (rsp_valid && rsp_error) |-> (rsp_last && idx_ff == 4'd0), "error beat not single")

endmodule

>>> rtl/utf8_to_json_escaped_ascii.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_in_byte[7:0], req_end_of_text
// rsp       out        rsp_valid / rsp_ready  rsp_out_char[6:0], rsp_last, rsp_error
// csr       in         csr_wr_en              csr_wr_data (hex_uppercase)
//
// one byte is taken per cycle while the job queue has room; the first character
// of its expansion appears at the earliest the cycle after it is accepted
// the emitter sends one character per cycle while rsp_ready is high, so a byte costs 1, 2, 6 or 12
// characters (error beats 1, partial sequences 0); the emitter sets the sustained rate
// reset is synchronous and clears the decode state, the queue and the hex case
// rsp_ready low stalls only the emitter; bytes keep entering until QUEUE_DEPTH
// jobs are waiting

module utf8_to_json_escaped_ascii #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last,
   output logic       rsp_error,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   // hex case register; the user must write it only while the block is idle, the block does not enforce this
   logic hex_upper_ff;

   logic             space;
   logic             job_valid;
   utj_pkg::job_type job;
   logic             head_valid;
   utj_pkg::job_type head_job;
   logic             pop;

   always_ff @(posedge clock) begin
      if (reset)          hex_upper_ff <= 1'b0;
      else if (csr_wr_en) hex_upper_ff <= csr_wr_data;
   end

   // decoder: classifies each byte and gathers multi-byte sequences
   utj_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .space           (space),
      .job_valid       (job_valid),
      .job             (job)
   );

   // short job queue between decoder and emitter
   utj_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_job   (job),
      .space      (space),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // emitter: expands each job into escaped ascii, one beat per character
   utj_back u_back (
      .clock        (clock),
      .reset        (reset),
      .hex_upper    (hex_upper_ff),
      .head_valid   (head_valid),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

endmodule
